// File: hw/rtl/tlm_pkg.sv
package tlm_pkg;

	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = 10;
	localparam int CFG_W     = 11;
	localparam int USER_W    = 16;
	localparam int TYPE_W    = 2;
	localparam int CNT_W     = 10;
	localparam int PROD_W    = 21;
	localparam int DIV_CNT_W = 4;

	localparam logic [TYPE_W-1:0] REQ_LOCK    = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_UNLOCK  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_UPGRADE = 2'd2;

	localparam logic REG_ARITY      = 1'b0;
	localparam logic REG_NODE_COUNT = 1'b1;

	// table address source
	localparam logic [1:0] ADDR_NODE = 2'd0;
	localparam logic [1:0] ADDR_CUR  = 2'd1;
	localparam logic [1:0] ADDR_J    = 2'd2;
	localparam logic [1:0] ADDR_CLR  = 2'd3;

	// table write operations
	localparam logic [2:0] WR_NONE      = 3'd0;
	localparam logic [2:0] WR_NODE_LOCK = 3'd1;
	localparam logic [2:0] WR_NODE_UNLK = 3'd2;
	localparam logic [2:0] WR_ADJ       = 3'd3;
	localparam logic [2:0] WR_ZERO      = 3'd4;

	// ancestor count change
	localparam logic [1:0] DELTA_INC = 2'd0;
	localparam logic [1:0] DELTA_DEC = 2'd1;
	localparam logic [1:0] DELTA_UPG = 2'd2;

	typedef struct packed {
		logic       take;
		logic [1:0] addr_sel;
		logic       rd_en;
		logic [2:0] wr_op;
		logic       cur_node;
		logic       div_start;
		logic       cur_div;
		logic       delta_load;
		logic [1:0] delta_sel;
		logic       k_load;
		logic       lo_init;
		logic       lvl_next;
		logic       lvl_set;
		logic       j_inc;
		logic       clr_inc;
	} cmd_t;

	typedef struct packed {
		logic              in_range;
		logic [TYPE_W-1:0] req_type;
		logic              rd_locked;
		logic              rd_cnt_zero;
		logic              own_match;
		logic              cur_zero;
		logic              div_done;
		logic              lvl_end;
		logic              j_last;
		logic              clr_last;
	} sts_t;

endpackage

// File: hw/rtl/tree_lock_manager.sv
// Lock table over a complete tree: one request in, one granted/refused result out.
// Each request reads its node; lock and upgrade walk the ancestors one parent step at a time
//   (each step waits on the parent divider); upgrade then sweeps the subtree level by level
//   twice, checking descendants and then clearing them; ancestor counts are adjusted last.
// Reset (arst_n, async) and every register write start a clearing pass over all 1024
//   entries of the lock table; no request is taken until it ends. One request at a time.
module tree_lock_manager (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: index 0 arity, index 1 node_count
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // req_type[1:0], node_index[11:2], user_id[27:12], zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // granted[0], zero
);

	tlm_pkg::cmd_t cmd;
	tlm_pkg::sts_t sts;
	logic          res_load;
	logic          res_grant;
	logic          m_tvalid_q;
	logic          granted_q;

	// Controller: sequences table reads, parent steps and subtree sweeps.
	tlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.out_free  (!m_tvalid_q || m_tready),
		.res_load  (res_load),
		.res_grant (res_grant),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: config registers, lock/count and owner tables, divider, level multiplier.
	tlm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (s_tdata[1:0]),
		.node_index (s_tdata[11:2]),
		.user_id    (s_tdata[27:12]),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Output register: hold the result until taken; a new request may already be at work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			granted_q <= res_grant;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, granted_q};

endmodule

// File: hw/rtl/tlm_div.sv
module tlm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tlm_pkg::NODE_W-1:0]  dividend,
	input  logic [tlm_pkg::CFG_W-1:0]   divisor,
	output logic                        done,
	output logic [tlm_pkg::NODE_W-1:0]  quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [tlm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [tlm_pkg::CFG_W-1:0]      rem_q;
	logic [tlm_pkg::NODE_W-1:0]     quo_q;
	logic [tlm_pkg::CFG_W:0]        trial;
	logic                           ge;

	assign trial = {rem_q, quo_q[tlm_pkg::NODE_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tlm_pkg::DIV_CNT_W'(tlm_pkg::NODE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tlm_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? tlm_pkg::CFG_W'(trial - {1'b0, divisor}) : trial[tlm_pkg::CFG_W-1:0];
			quo_q <= {quo_q[tlm_pkg::NODE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/tlm_datapath.sv
module tlm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tlm_pkg::CFG_W-1:0]   cfg_data,
	input  logic [tlm_pkg::TYPE_W-1:0]  req_type,
	input  logic [tlm_pkg::NODE_W-1:0]  node_index,
	input  logic [tlm_pkg::USER_W-1:0]  user_id,
	input  tlm_pkg::cmd_t               cmd,
	output tlm_pkg::sts_t               sts
);

	logic [tlm_pkg::CFG_W-1:0]   arity_q;
	logic [tlm_pkg::CFG_W-1:0]   node_count_q;
	logic [tlm_pkg::TYPE_W-1:0]  type_q;
	logic [tlm_pkg::NODE_W-1:0]  node_q;
	logic [tlm_pkg::USER_W-1:0]  user_q;
	logic [tlm_pkg::NODE_W-1:0]  cur_q;
	logic [tlm_pkg::CNT_W-1:0]   delta_q;
	logic [tlm_pkg::CNT_W-1:0]   k_q;
	logic [tlm_pkg::PROD_W-1:0]  lo_q;
	logic [tlm_pkg::PROD_W-1:0]  hi_q;
	logic [tlm_pkg::NODE_W-1:0]  j_q;
	logic [tlm_pkg::NODE_W-1:0]  clr_q;
	logic                        rd_lock_q;
	logic [tlm_pkg::CNT_W-1:0]   rd_cnt_q;
	logic [tlm_pkg::USER_W-1:0]  rd_own_q;

	logic [tlm_pkg::CNT_W:0]     state_mem [tlm_pkg::MAX_NODES];
	logic [tlm_pkg::USER_W-1:0]  owner_mem [tlm_pkg::MAX_NODES];

	logic [tlm_pkg::CFG_W-1:0]   n_cap;
	logic [tlm_pkg::CFG_W-1:0]   n_live;
	logic [tlm_pkg::NODE_W-1:0]  addr;
	logic [tlm_pkg::CNT_W:0]     wdata;
	logic                        wr_en;
	logic                        div_done;
	logic [tlm_pkg::NODE_W-1:0]  div_quo;
	logic [tlm_pkg::PROD_W-1:0]  n_wide;

	tlm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cur_q - 1'b1),
		.divisor  (arity_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		n_cap = (node_count_q > tlm_pkg::CFG_W'(tlm_pkg::MAX_NODES))
			? tlm_pkg::CFG_W'(tlm_pkg::MAX_NODES) : node_count_q;
		n_live = (arity_q == '0 && n_cap > tlm_pkg::CFG_W'(1)) ? tlm_pkg::CFG_W'(1) : n_cap;
		n_wide = tlm_pkg::PROD_W'(n_live);
	end

	always_comb begin
		case (cmd.addr_sel)
			tlm_pkg::ADDR_NODE: addr = node_q;
			tlm_pkg::ADDR_CUR:  addr = cur_q;
			tlm_pkg::ADDR_J:    addr = j_q;
			default:            addr = clr_q;
		endcase
	end

	always_comb begin
		wr_en = 1'b1;
		wdata = '0;
		unique case (cmd.wr_op)
			tlm_pkg::WR_NONE:      wr_en = 1'b0;
			tlm_pkg::WR_NODE_LOCK: wdata = {1'b1, {tlm_pkg::CNT_W{1'b0}}};
			tlm_pkg::WR_NODE_UNLK: wdata = {1'b0, rd_cnt_q};
			tlm_pkg::WR_ADJ:       wdata = {rd_lock_q, rd_cnt_q + delta_q};
			tlm_pkg::WR_ZERO:      wdata = '0;
			default:               wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			state_mem[addr] <= wdata;
		if (cmd.wr_op == tlm_pkg::WR_NODE_LOCK)
			owner_mem[addr] <= user_q;
		if (cmd.rd_en) begin
			{rd_lock_q, rd_cnt_q} <= state_mem[addr];
			rd_own_q <= owner_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arity_q      <= tlm_pkg::CFG_W'(2);
			node_count_q <= tlm_pkg::CFG_W'(tlm_pkg::MAX_NODES);
			clr_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tlm_pkg::REG_ARITY:      arity_q <= cfg_data;
					tlm_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
					default:                 arity_q <= arity_q;
				endcase
				clr_q <= '0;
			end else if (cmd.clr_inc) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			type_q <= req_type;
			node_q <= node_index;
			user_q <= user_id;
		end
		if (cmd.cur_node)
			cur_q <= node_q;
		else if (cmd.cur_div)
			cur_q <= div_quo;
		if (cmd.k_load)
			k_q <= rd_cnt_q;
		if (cmd.delta_load) begin
			case (cmd.delta_sel)
				tlm_pkg::DELTA_INC: delta_q <= tlm_pkg::CNT_W'(1);
				tlm_pkg::DELTA_DEC: delta_q <= '1;
				default:            delta_q <= tlm_pkg::CNT_W'(1) - k_q;
			endcase
		end
		if (cmd.lo_init) begin
			lo_q <= tlm_pkg::PROD_W'(node_q);
			hi_q <= tlm_pkg::PROD_W'(node_q);
		end else if (cmd.lvl_next) begin
			lo_q <= tlm_pkg::PROD_W'(lo_q[tlm_pkg::NODE_W-1:0]) * tlm_pkg::PROD_W'(arity_q)
				+ tlm_pkg::PROD_W'(1);
			hi_q <= tlm_pkg::PROD_W'(hi_q[tlm_pkg::NODE_W-1:0]) * tlm_pkg::PROD_W'(arity_q)
				+ tlm_pkg::PROD_W'(arity_q);
		end else if (cmd.lvl_set) begin
			if (hi_q >= n_wide)
				hi_q <= n_wide - 1'b1;
		end
		if (cmd.lvl_set)
			j_q <= lo_q[tlm_pkg::NODE_W-1:0];
		else if (cmd.j_inc)
			j_q <= j_q + 1'b1;
	end

	always_comb begin
		sts.in_range    = tlm_pkg::CFG_W'(node_q) < n_live;
		sts.req_type    = type_q;
		sts.rd_locked   = rd_lock_q;
		sts.rd_cnt_zero = rd_cnt_q == '0;
		sts.own_match   = rd_own_q == user_q;
		sts.cur_zero    = cur_q == '0;
		sts.div_done    = div_done;
		sts.lvl_end     = lo_q >= n_wide;
		sts.j_last      = j_q == hi_q[tlm_pkg::NODE_W-1:0];
		sts.clr_last    = clr_q == tlm_pkg::NODE_W'(tlm_pkg::MAX_NODES - 1);
	end

endmodule

// File: hw/rtl/tlm_ctrl.sv
module tlm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           out_free,
	output logic           res_load,
	output logic           res_grant,
	output tlm_pkg::cmd_t  cmd,
	input  tlm_pkg::sts_t  sts
);

	localparam logic [4:0] ST_CLEAR    = 5'd0;
	localparam logic [4:0] ST_IDLE     = 5'd1;
	localparam logic [4:0] ST_RD_NODE  = 5'd2;
	localparam logic [4:0] ST_EVAL     = 5'd3;
	localparam logic [4:0] ST_CHK_TEST = 5'd4;
	localparam logic [4:0] ST_CHK_DIV  = 5'd5;
	localparam logic [4:0] ST_CHK_RD   = 5'd6;
	localparam logic [4:0] ST_CHK_EX   = 5'd7;
	localparam logic [4:0] ST_W_NEXT   = 5'd8;
	localparam logic [4:0] ST_W_LVL    = 5'd9;
	localparam logic [4:0] ST_W_RD     = 5'd10;
	localparam logic [4:0] ST_W_EX     = 5'd11;
	localparam logic [4:0] ST_W_ZR     = 5'd12;
	localparam logic [4:0] ST_ADJ_TEST = 5'd13;
	localparam logic [4:0] ST_ADJ_DIV  = 5'd14;
	localparam logic [4:0] ST_ADJ_RD   = 5'd15;
	localparam logic [4:0] ST_ADJ_WR   = 5'd16;
	localparam logic [4:0] ST_PASS     = 5'd17;
	localparam logic [4:0] ST_FAIL     = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       clr_pass_q;
	logic       clr_pass_d;

	assign req_ready = (state_q == ST_IDLE) && !cfg_we;

	always_comb begin
		state_d    = state_q;
		clr_pass_d = clr_pass_q;
		cmd        = '0;
		res_load   = 1'b0;
		res_grant  = 1'b0;
		unique case (state_q) inside
			ST_CLEAR: begin
				cmd.addr_sel = tlm_pkg::ADDR_CLR;
				cmd.wr_op    = tlm_pkg::WR_ZERO;
				cmd.clr_inc  = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid && req_ready) begin
					cmd.take = 1'b1;
					state_d  = ST_RD_NODE;
				end
			end
			ST_RD_NODE: begin
				cmd.addr_sel = tlm_pkg::ADDR_NODE;
				cmd.rd_en    = 1'b1;
				state_d      = sts.in_range ? ST_EVAL : ST_FAIL;
			end
			ST_EVAL: begin
				state_d = ST_FAIL;
				case (sts.req_type)
					tlm_pkg::REQ_LOCK: begin
						if (!sts.rd_locked && sts.rd_cnt_zero) begin
							cmd.cur_node = 1'b1;
							state_d      = ST_CHK_TEST;
						end
					end
					tlm_pkg::REQ_UNLOCK: begin
						if (sts.rd_locked && sts.own_match) begin
							cmd.addr_sel   = tlm_pkg::ADDR_NODE;
							cmd.wr_op      = tlm_pkg::WR_NODE_UNLK;
							cmd.delta_load = 1'b1;
							cmd.delta_sel  = tlm_pkg::DELTA_DEC;
							cmd.cur_node   = 1'b1;
							state_d        = ST_ADJ_TEST;
						end
					end
					tlm_pkg::REQ_UPGRADE: begin
						if (!sts.rd_locked && !sts.rd_cnt_zero) begin
							cmd.k_load   = 1'b1;
							cmd.cur_node = 1'b1;
							state_d      = ST_CHK_TEST;
						end
					end
					default: state_d = ST_FAIL;
				endcase
			end
			ST_CHK_TEST: begin
				if (!sts.cur_zero) begin
					cmd.div_start = 1'b1;
					state_d       = ST_CHK_DIV;
				end else if (sts.req_type == tlm_pkg::REQ_LOCK) begin
					cmd.addr_sel   = tlm_pkg::ADDR_NODE;
					cmd.wr_op      = tlm_pkg::WR_NODE_LOCK;
					cmd.delta_load = 1'b1;
					cmd.delta_sel  = tlm_pkg::DELTA_INC;
					cmd.cur_node   = 1'b1;
					state_d        = ST_ADJ_TEST;
				end else begin
					clr_pass_d  = 1'b0;
					cmd.lo_init = 1'b1;
					state_d     = ST_W_NEXT;
				end
			end
			ST_CHK_DIV: begin
				if (sts.div_done) begin
					cmd.cur_div = 1'b1;
					state_d     = ST_CHK_RD;
				end
			end
			ST_CHK_RD: begin
				cmd.addr_sel = tlm_pkg::ADDR_CUR;
				cmd.rd_en    = 1'b1;
				state_d      = ST_CHK_EX;
			end
			ST_CHK_EX: begin
				state_d = sts.rd_locked ? ST_FAIL : ST_CHK_TEST;
			end
			ST_W_NEXT: begin
				cmd.lvl_next = 1'b1;
				state_d      = ST_W_LVL;
			end
			ST_W_LVL: begin
				if (!sts.lvl_end) begin
					cmd.lvl_set = 1'b1;
					state_d     = clr_pass_q ? ST_W_ZR : ST_W_RD;
				end else if (!clr_pass_q) begin
					clr_pass_d  = 1'b1;
					cmd.lo_init = 1'b1;
					state_d     = ST_W_NEXT;
				end else begin
					cmd.addr_sel   = tlm_pkg::ADDR_NODE;
					cmd.wr_op      = tlm_pkg::WR_NODE_LOCK;
					cmd.delta_load = 1'b1;
					cmd.delta_sel  = tlm_pkg::DELTA_UPG;
					cmd.cur_node   = 1'b1;
					state_d        = ST_ADJ_TEST;
				end
			end
			ST_W_RD: begin
				cmd.addr_sel = tlm_pkg::ADDR_J;
				cmd.rd_en    = 1'b1;
				state_d      = ST_W_EX;
			end
			ST_W_EX: begin
				if (sts.rd_locked && !sts.own_match) begin
					state_d = ST_FAIL;
				end else if (sts.j_last) begin
					state_d = ST_W_NEXT;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = ST_W_RD;
				end
			end
			ST_W_ZR: begin
				cmd.addr_sel = tlm_pkg::ADDR_J;
				cmd.wr_op    = tlm_pkg::WR_ZERO;
				if (sts.j_last)
					state_d = ST_W_NEXT;
				else
					cmd.j_inc = 1'b1;
			end
			ST_ADJ_TEST: begin
				if (sts.cur_zero) begin
					state_d = ST_PASS;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_ADJ_DIV;
				end
			end
			ST_ADJ_DIV: begin
				if (sts.div_done) begin
					cmd.cur_div = 1'b1;
					state_d     = ST_ADJ_RD;
				end
			end
			ST_ADJ_RD: begin
				cmd.addr_sel = tlm_pkg::ADDR_CUR;
				cmd.rd_en    = 1'b1;
				state_d      = ST_ADJ_WR;
			end
			ST_ADJ_WR: begin
				cmd.addr_sel = tlm_pkg::ADDR_CUR;
				cmd.wr_op    = tlm_pkg::WR_ADJ;
				state_d      = ST_ADJ_TEST;
			end
			ST_PASS, ST_FAIL: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_grant = state_q == ST_PASS;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_we)
			state_d = ST_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_pass_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_pass_q <= clr_pass_d;
		end
	end

`ifndef SYNTH
	a_div_needs_parent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.cur_zero)
		else $error("parent step started at the root");
	a_take_reads_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_RD_NODE)
		else $error("accepted request did not start");
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> state_q == ST_CLEAR)
		else $error("register write did not start the clearing pass");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> !res_load)
		else $error("two results for one request");
`endif

endmodule

// File: test/tb_tree_lock_manager.sv
`timescale 1ns / 100ps

module tb_tree_lock_manager;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [10:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // req_type[1:0], node_index[11:2], user_id[27:12], zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // granted[0], zero

	tree_lock_manager dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [tlm_pkg::USER_W-1:0] user;
		logic [tlm_pkg::NODE_W-1:0] node;
		logic [tlm_pkg::TYPE_W-1:0] kind;
	} lock_req_t;

	// predictor state: shape registers and the lock table
	int unsigned  tree_arity;
	int unsigned  tree_nodes;
	bit           held[tlm_pkg::MAX_NODES];
	int unsigned  holder[tlm_pkg::MAX_NODES];
	int unsigned  below[tlm_pkg::MAX_NODES];

	lock_req_t    pending_reqs[$];
	bit           grant_queue[$];
	int           error_count;
	int           hold_cycles;
	int           gap_left;
	int           burst_left;
	int           stall_phase;
	bit           cfg_busy;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic void wipe_table();
		for (int i = 0; i < tlm_pkg::MAX_NODES; i++) begin
			held[i] = 0;
			holder[i] = 0;
			below[i] = 0;
		end
	endfunction

	function automatic int unsigned live_count();
		int unsigned n;
		n = (tree_nodes > tlm_pkg::MAX_NODES) ? tlm_pkg::MAX_NODES : tree_nodes;
		if (tree_arity == 0 && n > 1)
			n = 1;
		return n;
	endfunction

	function automatic bit any_ancestor_held(int unsigned i);
		while (i > 0) begin
			i = (i - 1) / tree_arity;
			if (held[i])
				return 1;
		end
		return 0;
	endfunction

	function automatic void bump_ancestors(int unsigned i, int unsigned delta);
		while (i > 0) begin
			i = (i - 1) / tree_arity;
			below[i] = below[i] + delta;
		end
	endfunction

	// walk the subtree level by level; check ownership or clear it
	function automatic bit sweep_subtree(int unsigned i, int unsigned n, bit clear,
			int unsigned user);
		longint unsigned m, lo, hi;
		m = tree_arity;
		if (m == 0)
			return 1;
		lo = i * m + 1;
		hi = i * m + m;
		while (lo < n) begin
			if (hi >= n)
				hi = n - 1;
			for (longint unsigned j = lo; j <= hi; j++) begin
				if (clear) begin
					held[j] = 0;
					below[j] = 0;
				end else if (held[j] && holder[j] != user)
					return 0;
			end
			lo = lo * m + 1;
			hi = hi * m + m;
		end
		return 1;
	endfunction

	// compute the grant for one request and update the lock table
	function automatic bit grant_of(lock_req_t r);
		int unsigned n, k;
		n = live_count();
		if (r.node >= n)
			return 0;
		case (r.kind)
			tlm_pkg::REQ_LOCK: begin
				if (!held[r.node] && below[r.node] == 0 && !any_ancestor_held(r.node)) begin
					held[r.node] = 1;
					holder[r.node] = r.user;
					bump_ancestors(r.node, 1);
					return 1;
				end
			end
			tlm_pkg::REQ_UNLOCK: begin
				if (held[r.node] && holder[r.node] == r.user) begin
					held[r.node] = 0;
					bump_ancestors(r.node, 32'hFFFF_FFFF);
					return 1;
				end
			end
			tlm_pkg::REQ_UPGRADE: begin
				if (!held[r.node] && below[r.node] != 0 && !any_ancestor_held(r.node)
						&& sweep_subtree(r.node, n, 0, r.user)) begin
					k = below[r.node];
					void'(sweep_subtree(r.node, n, 1, r.user));
					below[r.node] = 0;
					held[r.node] = 1;
					holder[r.node] = r.user;
					bump_ancestors(r.node, 1 - k);
					return 1;
				end
			end
			default: ;
		endcase
		return 0;
	endfunction

	function automatic void push_req(logic [1:0] kind, int unsigned node, int unsigned user);
		lock_req_t r;
		r.kind = kind;
		r.node = node[tlm_pkg::NODE_W-1:0];
		r.user = user[tlm_pkg::USER_W-1:0];
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	// driver: bursts with random gaps; hold valid high between requests in a burst
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				grant_queue.insert(grant_queue.size(), grant_of(pending_reqs.pop_front()));
			end
			if ((s_tvalid && !s_tready) || cfg_busy) begin
				// hold current offer, or stay quiet during a register phase
			end else if (pending_reqs.size() > 0 && gap_left == 0) begin
				// head of the queue is the next request to offer
				lock_req_t nxt;
				nxt = pending_reqs[0];
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, nxt};
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
				end else if (burst_left == 1) begin
					burst_left <= 0;
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (grant_queue.size() == 0) begin
					$display("%0t: unexpected result granted=%0b", $time, m_tdata[0]);
					error_count++;
				end else begin
					bit want;
					want = grant_queue.pop_front();
					if (m_tdata[0] !== want || m_tdata[7:1] !== 7'b0) begin
						$display("%0t: granted mismatch expected %0b actual %0b (tdata %h)",
							$time, want, m_tdata[0], m_tdata);
						error_count++;
					end
				end
			end
			stall_phase <= (stall_phase + 1) % 23;
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (stall_phase < 8) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= (stall_phase % 3 != 0) && ($urandom_range(0, 4) != 0);
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || grant_queue.size() > 0)
			@(posedge clk);
		// let any in-flight walk finish
		repeat (20000) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[10:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tlm_pkg::REG_ARITY)
			tree_arity = val & 11'h7FF;
		else
			tree_nodes = val & 11'h7FF;
		wipe_table();
	endtask

	// random locks, unlocks, malformed requests and lock/upgrade/unlock runs
	task automatic queue_random(int count, int unsigned span);
		int unsigned user, nd, anc;
		for (int i = 0; i < count; i++) begin
			user = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3);
			case ($urandom_range(0, 9))
				0, 1, 2: push_req(tlm_pkg::REQ_LOCK, $urandom_range(0, span), user);
				3, 4: push_req(tlm_pkg::REQ_UNLOCK, $urandom_range(0, span), user);
				5: push_req($urandom_range(0, 3), $urandom, $urandom);
				default: begin
					anc = $urandom_range(0, span / 4);
					nd = anc;
					for (int d = 0; d < 3 && tree_arity > 0; d++)
						nd = nd * tree_arity + $urandom_range(1, tree_arity > 4 ? 4 : tree_arity);
					push_req(tlm_pkg::REQ_LOCK, nd, user);
					push_req(tlm_pkg::REQ_UPGRADE, anc, user);
					push_req(tlm_pkg::REQ_UNLOCK, anc,
						$urandom_range(0, 4) == 0 ? user + 1 : user);
					i += 2;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		cfg_busy = 1'b1;
		error_count = 0;
		hold_cycles = 0;
		tree_arity = 2;
		tree_nodes = 1024;
		wipe_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every request type, an invalid type
		push_req(tlm_pkg::REQ_LOCK, 1023, 16'hFFFF);
		push_req(tlm_pkg::REQ_UNLOCK, 1023, 16'hFFFE);
		push_req(tlm_pkg::REQ_UNLOCK, 1023, 16'hFFFF);
		push_req(tlm_pkg::REQ_LOCK, 3, 0);
		push_req(tlm_pkg::REQ_LOCK, 4, 0);
		push_req(tlm_pkg::REQ_LOCK, 1, 7);
		push_req(tlm_pkg::REQ_UPGRADE, 1, 1);
		push_req(tlm_pkg::REQ_UPGRADE, 1, 0);
		push_req(tlm_pkg::REQ_LOCK, 0, 5);
		push_req(tlm_pkg::REQ_UPGRADE, 0, 0);
		push_req(tlm_pkg::REQ_UNLOCK, 1, 0);
		push_req(tlm_pkg::REQ_UPGRADE, 2, 0);
		push_req(2'd3, 0, 0);
		push_req(2'd3, 1023, 16'hFFFF);
		push_req(tlm_pkg::REQ_LOCK, 0, 16'h5555);
		push_req(tlm_pkg::REQ_LOCK, 6, 16'hAAAA);
		cfg_busy = 1'b0;
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		cfg_busy = 1'b1;
		write_reg(tlm_pkg::REG_NODE_COUNT, 1024);
		write_reg(tlm_pkg::REG_ARITY, 1);
		cfg_busy = 1'b0;
		queue_random(20, 40);
		hold_cycles = 3000;
		wait_drained();

		// walk through shapes: extremes and ordinary ones
		begin
			int unsigned shapes[10][2];
			shapes = '{
				'{0, 5}, '{1024, 1024}, '{2, 0}, '{3, 100}, '{2, 1024},
				'{4, 300}, '{2047, 1}, '{1, 2047}, '{5, 200}, '{2, 63}};
			for (int s = 0; s < 10; s++) begin
				cfg_busy = 1'b1;
				write_reg(tlm_pkg::REG_ARITY, shapes[s][0]);
				write_reg(tlm_pkg::REG_NODE_COUNT, shapes[s][1]);
				cfg_busy = 1'b0;
				queue_random(110, (s == 1 || s == 7) ? 1023 : 80);
				wait_drained();
			end
		end

		if (error_count == 0) begin
			$display("tb_tree_lock_manager: done, clean");
		end else begin
			$display("tb_tree_lock_manager: done, errors");
		end
		$finish;
	end

	initial begin
		#1s;
		$display("tb_tree_lock_manager: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/tlm_pkg.sv
hw/rtl/tlm_div.sv
hw/rtl/tlm_datapath.sv
hw/rtl/tlm_ctrl.sv
hw/rtl/tree_lock_manager.sv
test/tb_tree_lock_manager.sv
